@@ rtl/hsl2rgb_pkg.sv @@
// Shared constants and beat types for the HSL to RGB converter.
package hsl2rgb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = FRAC_BITS + 1;
   localparam int BYTE_W    = 8;

   typedef struct packed {
      logic [IN_W-1:0] hue;
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] lightness;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rsp_type;

endpackage

@@ rtl/hsl_to_rgb_converter.sv @@
// HSL to RGB converter: six-stage pipeline, one pixel per clock unless stalled.
//
// Takes one hue, saturation, lightness triple per beat (unsigned fixed point,
// FRAC_BITS fraction bits, 1.0 = 2^FRAC_BITS) and returns one 8-bit red,
// green, blue beat. The pipeline is six register stages deep, and a new
// request is taken in every cycle that the output is not stalled. All
// stages advance together; a stall on the response side holds every stage,
// and the request side is ready whenever the output register is empty or
// being drained. The stages are: input clamp, the lightness-saturation
// product and hue segment decode, forming q and p, the per-channel ramp
// multiply, the fixed-point sum, and the scale to a byte with clamping.
// Zero saturation returns gray.
module hsl_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hsl2rgb_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hsl2rgb_pkg::rsp_type rsp_data
);

   localparam int F      = hsl2rgb_pkg::FRAC_BITS;
   localparam int W      = hsl2rgb_pkg::IN_W;
   localparam int BW     = hsl2rgb_pkg::BYTE_W;
   localparam int HW     = W + 5;
   localparam int NUM_CH = 3;
   localparam int STAGES = 6;

   localparam logic [W-1:0] ONE  = W'(1) << F;
   localparam logic [W-1:0] HALF = W'(1) << (F - 1);

   // Hue is handled as six times its value so all breakpoints are integers.
   localparam logic signed [HW-1:0] SEG1 = $signed(HW'(1) << F);
   localparam logic signed [HW-1:0] SEG2 = $signed(HW'(2) << F);
   localparam logic signed [HW-1:0] SEG3 = $signed(HW'(3) << F);
   localparam logic signed [HW-1:0] SEG4 = $signed(HW'(4) << F);
   localparam logic signed [HW-1:0] FULL = $signed(HW'(6) << F);
   localparam logic signed [HW-1:0] HUE_OFS [NUM_CH] = '{SEG2, '0, -SEG2};

   logic              adv;
   logic [STAGES-1:0] vld_ff;

   // Stage 1: clamped inputs.
   logic [W-1:0] h1_ff, s1_ff, l1_ff, s1_in, l1_in;

   // Stage 2: product, gray byte, hue segments.
   logic [2*W-1:0]          prod2_ff, prod2_in;
   logic [W-1:0]            s2_ff, l2_ff;
   logic                    gray2_ff, gray2_in;
   logic [BW-1:0]           gbyte2_ff, gbyte2_in;
   logic [W+BW-1:0]         gwide;
   logic [HW-1:0]           h6_u;
   logic signed [HW-1:0]    h_sum  [NUM_CH];
   logic signed [HW-1:0]    h_wrap [NUM_CH];
   logic signed [HW-1:0]    h_rev  [NUM_CH];
   logic [NUM_CH-1:0]       useq2_ff, useq2_in;
   logic [W-1:0]            t2_ff [NUM_CH];
   logic [W-1:0]            t2_in [NUM_CH];

   // Stage 3: q, p and their difference.
   logic [2*W:0]            num3;
   logic [W-1:0]            q3_ff, p3_ff, d3_ff, q3_in, p3_in, d3_in;
   logic [NUM_CH-1:0]       useq3_ff;
   logic [W-1:0]            t3_ff [NUM_CH];
   logic                    gray3_ff;
   logic [BW-1:0]           gbyte3_ff;

   // Stage 4: ramp products.
   logic [2*W-1:0]          m4_ff [NUM_CH];
   logic [2*W-1:0]          m4_in [NUM_CH];
   logic [W-1:0]            base4_ff [NUM_CH];
   logic [W-1:0]            base4_in [NUM_CH];
   logic                    gray4_ff;
   logic [BW-1:0]           gbyte4_ff;

   // Stage 5: channel values at scale ONE squared.
   logic [2*W-1:0]          v5_ff [NUM_CH];
   logic [2*W-1:0]          v5_in [NUM_CH];
   logic                    gray5_ff;
   logic [BW-1:0]           gbyte5_ff;

   // Stage 6: output bytes.
   logic [2*W+BW-1:0]       bw6 [NUM_CH];
   logic [BW-1:0]           b6  [NUM_CH];
   hsl2rgb_pkg::rsp_type    rsp_ff, rsp_in;

   assign adv       = !vld_ff[STAGES-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_data  = rsp_ff;

   always_comb begin
      s1_in = (req_data.saturation > ONE) ? ONE : req_data.saturation;
      l1_in = (req_data.lightness > ONE) ? ONE : req_data.lightness;
   end

   always_comb begin
      prod2_in = (2*W)'(l1_ff) * (2*W)'(s1_ff);
      gwide    = (W+BW)'(l1_ff) * (W+BW)'(8'd255);
      gbyte2_in = (|gwide[W+BW-1:F+BW]) ? '1 : gwide[F+BW-1:F];
      gray2_in = (s1_ff == '0);
      h6_u     = (HW'(h1_ff) << 2) + (HW'(h1_ff) << 1);
      for (int c = 0; c < NUM_CH; c++) begin
         h_sum[c] = $signed(h6_u) + HUE_OFS[c];
         if (h_sum[c] < 0) begin
            h_wrap[c] = h_sum[c] + FULL;
         end else if (h_sum[c] > FULL) begin
            h_wrap[c] = h_sum[c] - FULL;
         end else begin
            h_wrap[c] = h_sum[c];
         end
         h_rev[c] = SEG4 - h_wrap[c];
         // Flat segments use t = 0 so the same base + d*t form covers them.
         if (h_wrap[c] < SEG1) begin
            useq2_in[c] = 1'b0;
            t2_in[c]    = h_wrap[c][W-1:0];
         end else if (h_wrap[c] < SEG3) begin
            useq2_in[c] = 1'b1;
            t2_in[c]    = '0;
         end else if (h_wrap[c] < SEG4) begin
            useq2_in[c] = 1'b0;
            t2_in[c]    = h_rev[c][W-1:0];
         end else begin
            useq2_in[c] = 1'b0;
            t2_in[c]    = '0;
         end
      end
   end

   always_comb begin
      if (l2_ff < HALF) begin
         num3 = ((2*W+1)'(l2_ff) << F) + (2*W+1)'(prod2_ff);
      end else begin
         num3 = (((2*W+1)'(l2_ff) + (2*W+1)'(s2_ff)) << F) - (2*W+1)'(prod2_ff);
      end
      q3_in = num3[F+W-1:F];
      p3_in = W'(((W+1)'(l2_ff) << 1) - (W+1)'(q3_in));
      d3_in = q3_in - p3_in;
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         m4_in[c]    = (2*W)'(d3_ff) * (2*W)'(t3_ff[c]);
         base4_in[c] = useq3_ff[c] ? q3_ff : p3_ff;
         v5_in[c]    = ((2*W)'(base4_ff[c]) << F) + m4_ff[c];
         bw6[c]      = ((2*W+BW)'(v5_ff[c]) << BW) - (2*W+BW)'(v5_ff[c]);
         b6[c]       = (|bw6[c][2*W+BW-1:2*F+BW]) ? '1 : bw6[c][2*F+BW-1:2*F];
      end
      if (gray5_ff) begin
         rsp_in = '{red: gbyte5_ff, green: gbyte5_ff, blue: gbyte5_ff};
      end else begin
         rsp_in = '{red: b6[0], green: b6[1], blue: b6[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_ff     <= req_data.hue;
         s1_ff     <= s1_in;
         l1_ff     <= l1_in;

         prod2_ff  <= prod2_in;
         s2_ff     <= s1_ff;
         l2_ff     <= l1_ff;
         gray2_ff  <= gray2_in;
         gbyte2_ff <= gbyte2_in;
         useq2_ff  <= useq2_in;
         t2_ff     <= t2_in;

         q3_ff     <= q3_in;
         p3_ff     <= p3_in;
         d3_ff     <= d3_in;
         useq3_ff  <= useq2_ff;
         t3_ff     <= t2_ff;
         gray3_ff  <= gray2_ff;
         gbyte3_ff <= gbyte2_ff;

         m4_ff     <= m4_in;
         base4_ff  <= base4_in;
         gray4_ff  <= gray3_ff;
         gbyte4_ff <= gbyte3_ff;

         v5_ff     <= v5_in;
         gray5_ff  <= gray4_ff;
         gbyte5_ff <= gbyte4_ff;

         rsp_ff    <= rsp_in;
      end
   end

endmodule

@@ rtl/hsl2rgb_checker.sv @@
// Port-level checks for the HSL to RGB converter, bound to the top level.
module hsl2rgb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hsl2rgb_pkg::rsp_type rsp_data
);

   // Reset empties the pipeline, so no beat is offered right after it.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // The pipeline only backs up when the output register is full and held.
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while output can drain");

   // A refused request means the output is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output stall");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (.*);

@@ verif/tb_hsl_to_rgb_converter.sv @@
// Testbench for the HSL to RGB converter: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;

   localparam int unsigned ONE_FP     = 1 << hsl2rgb_pkg::FRAC_BITS;
   localparam int unsigned IN_MAX     = (1 << hsl2rgb_pkg::IN_W) - 1;
   localparam int          RANDOM_PIX = 450;
   localparam int unsigned CYCLE_MAX  = 200000;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   hsl2rgb_pkg::req_type req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   hsl2rgb_pkg::rsp_type rsp_data;

   hsl2rgb_pkg::req_type pending_hsl[$];
   hsl2rgb_pkg::rsp_type expected_rgb[$];

   logic        req_taken    = 1'b0;
   int          req_count    = 0;
   int          rsp_count    = 0;
   int          error_count  = 0;
   int          total_pixels = 0;
   int unsigned cycle_count  = 0;

   int             burst_left   = 0;
   int             idle_left    = 0;
   int             holdoff_left = 0;
   bit             holdoff_done = 1'b0;
   int             mode_left    = 0;
   stall_kind_type stall_mode   = STALL_NONE;
   logic           ready_next;

   hsl_to_rgb_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scales a channel value held at ONE^2 to a byte, truncating and clamping.
   function automatic logic [hsl2rgb_pkg::BYTE_W-1:0] scale_to_byte(longint unsigned v2);
      longint unsigned b;
      b = (v2 * 255) >> (2 * hsl2rgb_pkg::FRAC_BITS);
      return (b > 255) ? 8'd255 : b[hsl2rgb_pkg::BYTE_W-1:0];
   endfunction

   // One channel of the piecewise ramp; hue6 is six times the offset hue at scale ONE.
   function automatic logic [hsl2rgb_pkg::BYTE_W-1:0] ramp_byte(longint unsigned p,
                                                                longint unsigned q,
                                                                longint hue6);
      longint          full_turn;
      longint          one_s;
      longint unsigned span;
      longint unsigned p_wide;
      full_turn = 6 * longint'(ONE_FP);
      one_s     = longint'(ONE_FP);
      span      = q - p;
      p_wide    = p * ONE_FP;
      // The hue is wrapped only once, so hue above 1.0 can stay past the last breakpoint.
      if (hue6 < 0)
         hue6 = hue6 + full_turn;
      if (hue6 > full_turn)
         hue6 = hue6 - full_turn;
      if (hue6 < one_s)
         return scale_to_byte(p_wide + span * longint'(hue6));
      if (hue6 < 3 * one_s)
         return scale_to_byte(q * ONE_FP);
      if (hue6 < 4 * one_s)
         return scale_to_byte(p_wide + span * longint'(4 * one_s - hue6));
      return scale_to_byte(p_wide);
   endfunction

   function automatic hsl2rgb_pkg::rsp_type convert_hsl(hsl2rgb_pkg::req_type px);
      longint unsigned      sat;
      longint unsigned      lit;
      longint unsigned      q;
      longint unsigned      p;
      longint unsigned      gray;
      longint               hue6;
      hsl2rgb_pkg::rsp_type rgb;
      sat = (px.saturation > ONE_FP) ? ONE_FP : px.saturation;
      lit = (px.lightness > ONE_FP) ? ONE_FP : px.lightness;
      if (sat == 0) begin
         gray = (lit * 255) >> hsl2rgb_pkg::FRAC_BITS;
         if (gray > 255)
            gray = 255;
         rgb.red   = gray[hsl2rgb_pkg::BYTE_W-1:0];
         rgb.green = gray[hsl2rgb_pkg::BYTE_W-1:0];
         rgb.blue  = gray[hsl2rgb_pkg::BYTE_W-1:0];
         return rgb;
      end
      if (lit < ONE_FP / 2)
         q = (lit * (ONE_FP + sat)) >> hsl2rgb_pkg::FRAC_BITS;
      else
         q = (lit * ONE_FP + sat * ONE_FP - lit * sat) >> hsl2rgb_pkg::FRAC_BITS;
      p = 2 * lit - q;
      hue6      = 6 * longint'(px.hue);
      rgb.red   = ramp_byte(p, q, hue6 + 2 * longint'(ONE_FP));
      rgb.green = ramp_byte(p, q, hue6);
      rgb.blue  = ramp_byte(p, q, hue6 - 2 * longint'(ONE_FP));
      return rgb;
   endfunction

   // Favors the ends of the range and 1/2, with some values past 1.0.
   function automatic int unsigned random_level();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ONE_FP;
         2: return ONE_FP / 2;
         3: return $urandom_range(0, IN_MAX);
         default: return $urandom_range(0, ONE_FP);
      endcase
   endfunction

   task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned lit);
      hsl2rgb_pkg::req_type px;
      px.hue        = hsl2rgb_pkg::IN_W'(hue);
      px.saturation = hsl2rgb_pkg::IN_W'(sat);
      px.lightness  = hsl2rgb_pkg::IN_W'(lit);
      pending_hsl.push_back(px);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (idle_left > 0 || pending_hsl.size() == 0) begin
            if (idle_left > 0)
               idle_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_hsl.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 30);
               idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
      end
   end

   // Receiver: stall style changes at random intervals, plus one long hold-off
   // that lets the pipeline fill and back up into the request side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!holdoff_done && rsp_count >= 120) begin
            holdoff_left = 300;
            holdoff_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = stall_kind_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            ready_next = 1'b0;
         end else begin
            case (stall_mode)
               STALL_NONE:  ready_next = 1'b1;
               STALL_HALF:  ready_next = 1'($urandom_range(0, 1));
               STALL_HEAVY: ready_next = ($urandom_range(0, 3) == 0);
               default:     ready_next = (cycle_count % 3 != 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // Monitor: predicts on each request beat and checks each response beat.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rgb.size() == 0) begin
               $error("response beat with no pixel outstanding: %0d %0d %0d",
                      rsp_data.red, rsp_data.green, rsp_data.blue);
               error_count++;
            end else begin
               hsl2rgb_pkg::rsp_type want;
               want = expected_rgb.pop_front();
               if (rsp_data.red !== want.red) begin
                  $error("red mismatch: expected %0d, got %0d", want.red, rsp_data.red);
                  error_count++;
               end
               if (rsp_data.green !== want.green) begin
                  $error("green mismatch: expected %0d, got %0d", want.green, rsp_data.green);
                  error_count++;
               end
               if (rsp_data.blue !== want.blue) begin
                  $error("blue mismatch: expected %0d, got %0d", want.blue, rsp_data.blue);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rgb.push_back(convert_hsl(req_data));
            req_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      // Gray: black, white, and lightness above 1.0.
      add_pixel(0, 0, 0);
      add_pixel(0, 0, ONE_FP);
      add_pixel(IN_MAX, 0, IN_MAX);
      add_pixel(12345, 0, 40000);
      // Primaries and secondaries at full saturation.
      add_pixel(0, ONE_FP, ONE_FP / 2);
      add_pixel(ONE_FP / 2, ONE_FP, ONE_FP / 2);
      add_pixel(ONE_FP, ONE_FP, ONE_FP / 2);
      add_pixel(ONE_FP / 6, ONE_FP, ONE_FP / 2);
      add_pixel(ONE_FP / 3, ONE_FP, ONE_FP / 2);
      add_pixel(2 * ONE_FP / 3, ONE_FP, ONE_FP / 2);
      add_pixel(5 * ONE_FP / 6, ONE_FP, ONE_FP / 2);
      // Lightness on either side of 1/2, and its ends.
      add_pixel(10923, ONE_FP, ONE_FP / 2 - 1);
      add_pixel(10923, ONE_FP / 2, ONE_FP / 2);
      add_pixel(IN_MAX, ONE_FP, 0);
      add_pixel(30000, 1, ONE_FP);
      add_pixel(1, 1, 1);
      add_pixel(ONE_FP - 1, ONE_FP - 1, ONE_FP - 1);
      // Saturation above 1.0 and hue above 1.0.
      add_pixel(20000, IN_MAX, 30000);
      add_pixel(IN_MAX, IN_MAX, ONE_FP / 2);
      add_pixel(3 * ONE_FP / 2, 40000, 20000);
      add_pixel(ONE_FP + 1, 50000, IN_MAX);
      add_pixel(7 * ONE_FP / 6, ONE_FP, ONE_FP / 2);
      for (int i = 0; i < RANDOM_PIX; i++)
         add_pixel(random_level(), random_level(), random_level());
      total_pixels = pending_hsl.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_count < total_pixels)
         @(posedge clock);
      while (expected_rgb.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
